// ===== hw/rtl/psm_pkg.sv =====
// Shared types and constants of the pulse speed meter.
package psm_pkg;

   localparam int FILT_SCALE_LOG = 6;
   localparam int MAX_JUMP       = 1280;
   localparam int SPEED_CAP      = 32767;
   localparam logic [3:0] BLANK_DIGIT = 4'd10;

   typedef enum logic [1:0] {
      REQ_CAPTURE = 2'd0,
      REQ_PULSE   = 2'd1,
      REQ_TICK    = 2'd2,
      REQ_REFRESH = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      MODE_COARSE  = 2'd0,
      MODE_PRECISE = 2'd1,
      MODE_ZERO    = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      CSR_PERIOD_COEF  = 3'd0,
      CSR_COUNT_COEF   = 3'd1,
      CSR_TO_COARSE    = 3'd2,
      CSR_TO_PRECISE   = 3'd3,
      CSR_ZERO_TIMEOUT = 3'd4,
      CSR_RECORD_SPEED = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_COARSE,
      ST_DIV_PRECISE,
      ST_FILTER,
      ST_DIGITS,
      ST_OUTPUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic event_apply;       // apply a non-refresh item, or latch a refresh item
      logic div_start;
      logic div_sel_prec;      // 0 coarse division, 1 precise division
      logic div_store_coarse;  // take finished coarse quotient
      logic div_store_prec;    // take finished precise quotient
      logic filter_step;       // mode decision, filter, maximum
      logic digit_start;
      logic out_load;
   } psm_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic div_done;
      logic digit_done;
   } psm_status_type;

endpackage

// ===== hw/rtl/psm_ctrl.sv =====
// Controller state machine of the pulse speed meter.
module psm_ctrl
   import psm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic [1:0]     req_type,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  psm_status_type status,
   output psm_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      req_take;

   assign req_take = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && req_type == REQ_REFRESH) state_in = ST_DIV_COARSE;
         end
         ST_DIV_COARSE: begin
            if (status.div_done) state_in = ST_DIV_PRECISE;
         end
         ST_DIV_PRECISE: begin
            if (status.div_done) state_in = ST_FILTER;
         end
         ST_FILTER: state_in = ST_DIGITS;
         ST_DIGITS: begin
            if (status.digit_done) state_in = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall        = 1'b0;
            cmd.event_apply  = req_take;
            cmd.div_start    = req_take && req_type == REQ_REFRESH;
         end
         ST_DIV_COARSE: begin
            // coarse quotient stored while the precise division starts
            cmd.div_store_coarse = status.div_done;
            cmd.div_start        = status.div_done;
            cmd.div_sel_prec     = status.div_done;
         end
         ST_DIV_PRECISE: begin
            cmd.div_sel_prec   = 1'b1;
            cmd.div_store_prec = status.div_done;
         end
         ST_FILTER: begin
            cmd.filter_step = 1'b1;
            cmd.digit_start = 1'b1;
         end
         ST_DIGITS: begin
            cmd.out_load = status.digit_done;
         end
         ST_OUTPUT: begin
            rsp_valid = 1'b1;
         end
         default: ;
      endcase
   end

endmodule

// ===== hw/rtl/psm_datapath.sv =====
// Datapath: event registers, serial divider, filter, maximum and digit split.
module psm_datapath
   import psm_pkg::*;
#(
   parameter int TIMER_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  psm_cmd_type           cmd,
   output psm_status_type        status,
   input  logic [1:0]            req_type,
   input  logic [15:0]           capture_time,
   input  logic                  show_max,
   input  logic                  csr_write,
   input  logic [2:0]            csr_index,
   input  logic [21:0]           csr_data,
   output logic [14:0]           rsp_display_speed,
   output logic [3:0]            rsp_ones_digit,
   output logic [3:0]            rsp_tens_digit,
   output logic [3:0]            rsp_hundreds_digit,
   output logic                  rsp_record_flag,
   output logic [1:0]            rsp_measure_mode
);

   localparam int TB = TIMER_BITS;                            // timer width
   localparam int PB = TB + 1;                                // period incl. 2^TB
   localparam int NB = 28;                                    // numerator bits
   localparam int DB = (PB > 16) ? PB : 16;                   // divisor bits
   localparam int CB = $clog2(NB + 1);

   // configuration
   logic [21:0] period_coef_ff;
   logic [15:0] count_coef_ff, to_coarse_ff, to_precise_ff, zero_timeout_ff;
   logic [9:0]  record_speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_coef_ff  <= 22'd500000;
         count_coef_ff   <= 16'd977;
         to_coarse_ff    <= 16'd1000;
         to_precise_ff   <= 16'd1440;
         zero_timeout_ff <= 16'd1000;
         record_speed_ff <= 10'd60;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PERIOD_COEF:  period_coef_ff  <= csr_data;
            CSR_COUNT_COEF:   count_coef_ff   <= csr_data[15:0];
            CSR_TO_COARSE:    to_coarse_ff    <= csr_data[15:0];
            CSR_TO_PRECISE:   to_precise_ff   <= csr_data[15:0];
            CSR_ZERO_TIMEOUT: zero_timeout_ff <= csr_data[15:0];
            CSR_RECORD_SPEED: record_speed_ff <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   // event state
   logic [TB-1:0] last_cap_ff, period_ff;
   logic [15:0]   tick_ff, held_ff;
   mode_type      mode_ff, mode_in;
   logic [23:0]   coarse_ff;
   logic signed [31:0] acc_ff;
   logic          first_ff;
   logic [14:0]   max_ff;
   logic          show_ff;
   logic [15:0]   tick_inc;
   logic [TB-1:0] stamp;
   logic [NB-1:0] precise_ff;

   assign tick_inc = tick_ff + 16'd1;
   assign stamp    = TB'(capture_time);

   // serial restoring divider
   logic [NB-1:0] num_ff;
   logic [DB:0]   rem_ff;
   logic [DB-1:0] den_ff;
   logic [CB-1:0] cnt_ff;
   logic          busy_ff;
   logic [DB:0]   rem_sh;
   logic [NB-1:0] div_num;
   logic [DB-1:0] div_den;

   always_comb begin
      if (cmd.div_sel_prec) begin
         div_num = {period_coef_ff, 6'd0};
         if (period_ff == '0) div_den = DB'({1'b1, {TB{1'b0}}});
         else                 div_den = DB'(period_ff);
      end else begin
         div_num = NB'({count_coef_ff, 6'd0});
         div_den = DB'(held_ff);
      end
   end

   assign rem_sh = {rem_ff[DB-1:0], num_ff[NB-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (cmd.div_start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CB'(NB);
         num_ff  <= div_num;
         den_ff  <= div_den;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_ff <= rem_sh - {1'b0, den_ff};
            num_ff <= {num_ff[NB-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            num_ff <= {num_ff[NB-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff - CB'(1);
         if (cnt_ff == CB'(1)) busy_ff <= 1'b0;
      end
   end

   logic done_ff;
   always_ff @(posedge clock) begin
      if (reset) done_ff <= 1'b0;
      else       done_ff <= busy_ff && cnt_ff == CB'(1);
   end
   assign status.div_done = done_ff;

   // filter
   logic signed [31:0] u_val, acc_base, diff, acc_new;
   logic [25:0]        shown_w;
   logic [14:0]        speed;
   logic               apply_f;

   always_comb begin
      mode_in = mode_ff;
      if (mode_ff == MODE_PRECISE && coarse_ff < 24'(to_coarse_ff))
         mode_in = MODE_COARSE;
      else if (mode_ff == MODE_COARSE && coarse_ff > 24'(to_precise_ff))
         mode_in = MODE_PRECISE;
      u_val    = (mode_in == MODE_COARSE) ? 32'(coarse_ff) : 32'(precise_ff);
      acc_base = first_ff ? u_val : acc_ff;
      diff     = u_val - acc_base;
      apply_f  = diff < 32'sd1280;
      // truncation toward zero
      acc_new  = acc_base + ((diff < 0) ? -((-diff) >>> FILT_SCALE_LOG)
                                        : (diff >>> FILT_SCALE_LOG));
      if (!apply_f) acc_new = acc_base;
      if (mode_in == MODE_ZERO) acc_new = '0;
   end

   always_comb begin
      if (acc_ff < 0) shown_w = '0;
      else            shown_w = 26'(acc_ff >>> FILT_SCALE_LOG);
      speed = (shown_w > 26'(SPEED_CAP)) ? 15'(SPEED_CAP) : shown_w[14:0];
   end

   logic       flag_ff;
   logic       speed_stage_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_cap_ff <= '0;
         period_ff   <= TB'(16'hFFFF);
         tick_ff     <= '0;
         held_ff     <= '0;
         mode_ff     <= MODE_ZERO;
         coarse_ff   <= '0;
         acc_ff      <= '0;
         first_ff    <= 1'b1;
      end else begin
         if (cmd.event_apply) begin
            case (req_type)
               REQ_CAPTURE: begin
                  period_ff   <= stamp - last_cap_ff;
                  last_cap_ff <= stamp;
               end
               REQ_PULSE: begin
                  tick_ff <= '0;
                  if (mode_ff == MODE_ZERO) begin
                     held_ff <= zero_timeout_ff;
                     mode_ff <= MODE_COARSE;
                  end else begin
                     held_ff <= tick_ff;
                  end
               end
               REQ_TICK: begin
                  if (tick_inc >= zero_timeout_ff) begin
                     tick_ff   <= '0;
                     coarse_ff <= '0;
                     mode_ff   <= MODE_ZERO;
                  end else begin
                     tick_ff <= tick_inc;
                  end
               end
               default: show_ff <= show_max;
            endcase
         end
         if (cmd.div_store_coarse && held_ff != '0)
            coarse_ff <= 24'(num_ff);
         if (cmd.div_store_prec)
            precise_ff <= num_ff;
         if (cmd.filter_step) begin
            mode_ff <= mode_in;
            acc_ff  <= acc_new;
            if (mode_in != MODE_ZERO) first_ff <= 1'b0;
         end
      end
   end

   // maximum and digits in the cycle after the filter step
   logic [14:0] speed_ff;
   logic [14:0] max_next;
   logic [14:0] shown;
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_stage_ff <= 1'b0;
         max_ff         <= '0;
         flag_ff        <= 1'b0;
      end else begin
         speed_stage_ff <= cmd.filter_step;
         if (speed_stage_ff) begin
            flag_ff <= 1'b0;
            if (speed > max_ff) begin
               max_ff  <= speed;
               flag_ff <= 15'(record_speed_ff) <= speed;
            end
         end
      end
   end
   assign speed_ff = speed;
   // maximum including the speed of this refresh, before max_ff catches up
   assign max_next = (speed > max_ff) ? speed : max_ff;

   // digit split by repeated subtraction, one hundred or ten per cycle
   logic [14:0] dv_ff;
   logic [3:0]  ones_q, tens_q;
   logic [3:0]  hund_ff, tens_ff;
   logic [1:0]  dphase_ff;   // 0 idle, 1 load, 2 hundreds, 3 tens
   logic        ddone_ff;

   assign shown = show_ff ? max_next : speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dphase_ff <= 2'd0;
         ddone_ff  <= 1'b0;
      end else begin
         ddone_ff <= 1'b0;
         case (dphase_ff)
            2'd0: if (cmd.digit_start) dphase_ff <= 2'd1;
            2'd1: begin
               dv_ff     <= shown;
               hund_ff   <= '0;
               tens_ff   <= '0;
               dphase_ff <= 2'd2;
            end
            2'd2: begin
               if (dv_ff >= 15'd100) begin
                  dv_ff   <= dv_ff - 15'd100;
                  hund_ff <= (hund_ff == 4'd9) ? 4'd0 : hund_ff + 4'd1;
               end else begin
                  dphase_ff <= 2'd3;
               end
            end
            default: begin
               if (dv_ff >= 15'd10) begin
                  dv_ff   <= dv_ff - 15'd10;
                  tens_ff <= tens_ff + 4'd1;
               end else begin
                  dphase_ff <= 2'd0;
                  ddone_ff  <= 1'b1;
               end
            end
         endcase
      end
   end
   assign status.digit_done = ddone_ff;
   assign ones_q = dv_ff[3:0];
   assign tens_q = tens_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_display_speed  <= shown;
         rsp_ones_digit     <= ones_q;
         rsp_tens_digit     <= (shown >= 15'd10) ? tens_q : BLANK_DIGIT;
         rsp_hundreds_digit <= (shown >= 15'd100) ? hund_ff : BLANK_DIGIT;
         rsp_record_flag    <= flag_ff;
         rsp_measure_mode   <= mode_ff;
      end
   end

endmodule

// ===== hw/rtl/pulse_speed_meter.sv =====
// Top level of the pulse speed meter: controller plus datapath.
// Capture, pulse and tick items are taken one per cycle while no refresh is in progress
// and give no result. A refresh item runs two 28-step serial divisions, a filter step
// and a digit split (one hundred or ten per cycle); no further item is taken until its
// result has been accepted.
// Synchronous active-high reset restores register defaults and zero mode.
module pulse_speed_meter
   import psm_pkg::*;
#(
   parameter int TIMER_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_capture_time,
   input  logic        req_show_max,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [14:0] rsp_display_speed,
   output logic [3:0]  rsp_ones_digit,
   output logic [3:0]  rsp_tens_digit,
   output logic [3:0]  rsp_hundreds_digit,
   output logic        rsp_record_flag,
   output logic [1:0]  rsp_measure_mode,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [21:0] csr_data
);

   psm_cmd_type    cmd;
   psm_status_type status;

   // sequencing of one item at a time
   psm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and state
   psm_datapath #(.TIMER_BITS(TIMER_BITS)) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_type           (req_type),
      .capture_time       (req_capture_time),
      .show_max           (req_show_max),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_display_speed  (rsp_display_speed),
      .rsp_ones_digit     (rsp_ones_digit),
      .rsp_tens_digit     (rsp_tens_digit),
      .rsp_hundreds_digit (rsp_hundreds_digit),
      .rsp_record_flag    (rsp_record_flag),
      .rsp_measure_mode   (rsp_measure_mode)
   );

endmodule

// ===== tb/pulse_speed_meter_tb.sv =====
// Self-checking testbench for the pulse speed meter: directed rows, then random event streams.
`timescale 1ns / 100ps

module pulse_speed_meter_tb
   import psm_pkg::*;
();

   typedef struct {
      logic [14:0] speed;
      logic [3:0]  ones;
      logic [3:0]  tens;
      logic [3:0]  hunds;
      logic        flag;
      logic [1:0]  mode;
   } speed_rec_type;

   typedef struct {
      req_kind_type  kind;
      logic [15:0]   stamp;
      logic          show;
      bit            typed;   // result written in below instead of predicted
      speed_rec_type want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = REQ_TICK;
   logic [15:0] req_capture_time = '0;
   logic        req_show_max = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [14:0] rsp_display_speed;
   logic [3:0]  rsp_ones_digit;
   logic [3:0]  rsp_tens_digit;
   logic [3:0]  rsp_hundreds_digit;
   logic        rsp_record_flag;
   logic [1:0]  rsp_measure_mode;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = CSR_PERIOD_COEF;
   logic [21:0] csr_data = '0;

   pulse_speed_meter uut (.*);

   always #5 clock = ~clock;

   // ---- predictor state: registers and the meter's own state ----
   longint unsigned   k_period, k_count, thr_coarse, thr_precise, zero_ticks, rec_speed;
   logic [15:0]       prev_stamp, period_reg, ticks, ticks_held;
   mode_type          cur_mode;
   longint unsigned   coarse_est;
   longint            acc;
   bit                seed_pending;
   int unsigned       peak;

   speed_rec_type     speed_q[$];
   int                n_fail = 0;
   int                n_refresh = 0, n_sat = 0, n_flag = 0;
   int                mode_hits[3] = '{0, 0, 0};
   int                snd_idle_pct = 0, rcv_idle_pct = 0;
   bit                hold_off = 1'b0;

   task automatic meter_reset();
      k_period = 500000; k_count = 977; thr_coarse = 1000; thr_precise = 1440;
      zero_ticks = 1000; rec_speed = 60;
      prev_stamp = 0; period_reg = 16'hFFFF; ticks = 0; ticks_held = 0;
      cur_mode = MODE_ZERO; coarse_est = 0; acc = 0; seed_pending = 1; peak = 0;
   endtask

   // Advances the meter by one event; got is set for a refresh.
   task automatic meter_event(input req_kind_type kind, input logic [15:0] stamp,
                              input logic show, output bit got, output speed_rec_type r);
      longint unsigned per, fine;
      longint          u, sw;
      int unsigned     spd, shown;
      bit              flag;
      got = 0;
      r = '{default: '0};
      case (kind)
         REQ_CAPTURE: begin
            period_reg = stamp - prev_stamp;
            prev_stamp = stamp;
         end
         REQ_PULSE: begin
            ticks_held = ticks;
            ticks = 0;
            if (cur_mode == MODE_ZERO) begin
               ticks_held = zero_ticks[15:0];
               cur_mode = MODE_COARSE;
            end
         end
         REQ_TICK: begin
            ticks = ticks + 16'd1;
            if (ticks >= zero_ticks) begin
               ticks = 0;
               coarse_est = 0;
               cur_mode = MODE_ZERO;
            end
         end
         default: begin
            per = (period_reg == 0) ? 65536 : period_reg;
            if (ticks_held != 0) coarse_est = (k_count * 64) / ticks_held;
            fine = (k_period * 64) / per;
            if (cur_mode == MODE_PRECISE && coarse_est < thr_coarse) cur_mode = MODE_COARSE;
            else if (cur_mode == MODE_COARSE && coarse_est > thr_precise) cur_mode = MODE_PRECISE;
            if (cur_mode != MODE_ZERO) begin
               u = (cur_mode == MODE_COARSE) ? longint'(coarse_est) : longint'(fine);
               if (seed_pending) begin
                  acc = u;
                  seed_pending = 0;
               end
               if (u - acc < 1280) acc = acc + (u - acc) / 64;   // truncates toward zero
            end else begin
               acc = 0;
            end
            sw = acc / 64;
            if (sw < 0) sw = 0;
            if (sw > SPEED_CAP) sw = SPEED_CAP;
            spd = int'(sw);
            flag = 0;
            if (spd > peak) begin
               peak = spd;
               if (peak >= rec_speed) flag = 1;
            end
            shown = show ? peak : spd;
            r.speed = shown[14:0];
            r.ones  = 4'(shown % 10);
            r.tens  = (shown >= 10) ? 4'((shown % 100) / 10) : BLANK_DIGIT;
            r.hunds = (shown >= 100) ? 4'((shown / 100) % 10) : BLANK_DIGIT;
            r.flag  = flag;
            r.mode  = cur_mode;
            got = 1;
            n_refresh++;
            if (spd == SPEED_CAP) n_sat++;
            if (flag) n_flag++;
            mode_hits[cur_mode]++;
         end
      endcase
   endtask

   // ---- sender ----
   task automatic send_item(input req_kind_type kind, input logic [15:0] stamp,
                            input logic show, input bit typed, input speed_rec_type want);
      bit            got;
      speed_rec_type r;
      @(negedge clock);
      if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(40, 1)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_capture_time <= stamp;
      req_show_max     <= show;
      do @(posedge clock); while (req_stall);
      meter_event(kind, stamp, show, got, r);
      if (got) speed_q.push_back(typed ? want : r);
   endtask

   task automatic quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (speed_q.size() == 0);
      repeat (500) @(posedge clock);   // a capture/pulse/tick may still be settling
   endtask

   task automatic write_reg(input csr_index_type idx, input longint unsigned val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val[21:0];
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_PERIOD_COEF:  k_period    = val & 22'h3FFFFF;
         CSR_COUNT_COEF:   k_count     = val & 16'hFFFF;
         CSR_TO_COARSE:    thr_coarse  = val & 16'hFFFF;
         CSR_TO_PRECISE:   thr_precise = val & 16'hFFFF;
         CSR_ZERO_TIMEOUT: zero_ticks  = val & 16'hFFFF;
         default:          rec_speed   = val & 10'h3FF;
      endcase
   endtask

   task automatic load_regs(input longint unsigned pc, cc, tc, tp, zt, rf);
      write_reg(CSR_PERIOD_COEF, pc);
      write_reg(CSR_COUNT_COEF, cc);
      write_reg(CSR_TO_COARSE, tc);
      write_reg(CSR_TO_PRECISE, tp);
      write_reg(CSR_ZERO_TIMEOUT, zt);
      write_reg(CSR_RECORD_SPEED, rf);
   endtask

   // Random stream: mostly revolutions (pulse, a few ticks, a capture, refresh),
   // with some loose events and occasional tick runs into standstill.
   task automatic random_items(input int n);
      speed_rec_type none;
      logic [15:0]   stamp;
      int            step, sent, j;
      none = '{default: '0};
      stamp = 16'($urandom);
      step = $urandom_range(200, 1);
      sent = 0;
      while (sent < n) begin
         case ($urandom_range(9))
            0: begin                          // loose event, any kind
               send_item(req_kind_type'($urandom_range(3)), 16'($urandom),
                         $urandom_range(1), 0, none);
               sent++;
            end
            1: begin                          // tick run, may reach the timeout
               for (j = 0; j < $urandom_range(40, 1); j++)
                  send_item(REQ_TICK, 16'($urandom), $urandom_range(1), 0, none);
               sent += j;
            end
            default: begin
               if ($urandom_range(9) == 0) step = $urandom;         // odd period, 0 too
               else if ($urandom_range(4) == 0) step = $urandom_range(3000, 1);
               send_item(REQ_PULSE, 16'($urandom), $urandom_range(1), 0, none);
               for (j = 0; j < $urandom_range(6); j++)
                  send_item(REQ_TICK, 16'($urandom), $urandom_range(1), 0, none);
               stamp = stamp + step[15:0];
               send_item(REQ_CAPTURE, stamp, $urandom_range(1), 0, none);
               send_item(REQ_REFRESH, 16'($urandom), $urandom_range(3) == 0, 0, none);
               sent += j + 3;
            end
         endcase
      end
   endtask

   // ---- receiver: random stalls, plus a long hold-off on request ----
   always @(negedge clock) begin
      if (hold_off) begin
         rsp_stall <= 1'b1;
         repeat (3000) @(negedge clock);
         hold_off = 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= (rcv_idle_pct != 0) && ($urandom_range(99) < rcv_idle_pct);
      end
   end

   // ---- result checker ----
   always @(posedge clock) begin
      speed_rec_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (speed_q.size() == 0) begin
            $display("%0t: result with none expected: speed %0d mode %0d", $time,
                     rsp_display_speed, rsp_measure_mode);
            n_fail++;
         end else begin
            e = speed_q.pop_front();
            if ({rsp_display_speed, rsp_ones_digit, rsp_tens_digit, rsp_hundreds_digit,
                 rsp_record_flag, rsp_measure_mode} !==
                {e.speed, e.ones, e.tens, e.hunds, e.flag, e.mode}) begin
               if (rsp_display_speed !== e.speed)
                  $display("%0t: speed exp %0d got %0d", $time, e.speed, rsp_display_speed);
               if (rsp_ones_digit !== e.ones)
                  $display("%0t: ones exp %0d got %0d", $time, e.ones, rsp_ones_digit);
               if (rsp_tens_digit !== e.tens)
                  $display("%0t: tens exp %0d got %0d", $time, e.tens, rsp_tens_digit);
               if (rsp_hundreds_digit !== e.hunds)
                  $display("%0t: hundreds exp %0d got %0d", $time, e.hunds,
                           rsp_hundreds_digit);
               if (rsp_record_flag !== e.flag)
                  $display("%0t: record exp %0d got %0d", $time, e.flag, rsp_record_flag);
               if (rsp_measure_mode !== e.mode)
                  $display("%0t: mode exp %0d got %0d", $time, e.mode, rsp_measure_mode);
               n_fail++;
            end
         end
      end
   end

   // ---- watchdog: cycles without any handshake ----
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 20000) begin
         $display("%0t: no progress, %0d results outstanding", $time, speed_q.size());
         $display("[pulse_speed_meter] ERROR");
         $finish;
      end
   end

   // ---- main sequence ----
   initial begin
      dir_row_type      rows[$];
      speed_rec_type    none, idle0, coarse0;
      int               i;
      none    = '{default: '0};
      // zero mode straight after reset: nothing shown, tens/hundreds blank
      idle0   = '{speed: 0, ones: 0, tens: BLANK_DIGIT, hunds: BLANK_DIGIT, flag: 0,
                  mode: MODE_ZERO};
      // first pulse leaves zero mode; seed 62 shows as 0 in coarse mode
      coarse0 = '{speed: 0, ones: 0, tens: BLANK_DIGIT, hunds: BLANK_DIGIT, flag: 0,
                  mode: MODE_COARSE};
      rows = '{
         '{REQ_REFRESH, 16'h0000, 1'b0, 1, idle0},
         '{REQ_REFRESH, 16'hFFFF, 1'b1, 1, idle0},
         '{REQ_CAPTURE, 16'h0000, 1'b0, 0, none},     // zero difference: full period
         '{REQ_PULSE,   16'h0000, 1'b0, 0, none},
         '{REQ_REFRESH, 16'h0000, 1'b0, 1, coarse0},
         '{REQ_CAPTURE, 16'hFFFF, 1'b1, 0, none},
         '{REQ_CAPTURE, 16'h0000, 1'b0, 0, none},     // timer wrap
         '{REQ_TICK,    16'h1234, 1'b1, 0, none},
         '{REQ_TICK,    16'h0000, 1'b0, 0, none},
         '{REQ_PULSE,   16'h0000, 1'b0, 0, none},     // held count 2: precise
         '{REQ_REFRESH, 16'h0000, 1'b0, 0, none},
         '{REQ_REFRESH, 16'h0000, 1'b1, 0, none},
         '{REQ_CAPTURE, 16'h0064, 1'b0, 0, none},
         '{REQ_CAPTURE, 16'h0065, 1'b0, 0, none},     // one-count period: jump
         '{REQ_PULSE,   16'h0000, 1'b0, 0, none},     // held count 0
         '{REQ_REFRESH, 16'h0000, 1'b0, 0, none},
         '{REQ_REFRESH, 16'h0000, 1'b1, 0, none},
         '{REQ_CAPTURE, 16'h8000, 1'b0, 0, none},
         '{REQ_REFRESH, 16'hAAAA, 1'b0, 0, none},
         '{REQ_REFRESH, 16'h5555, 1'b1, 0, none}
      };
      meter_reset();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < rows.size(); i++)
         send_item(rows[i].kind, rows[i].stamp, rows[i].show, rows[i].typed, rows[i].want);

      // high extremes; sender idles a little, receiver a lot
      quiesce();
      load_regs(22'h3FFFFF, 16'hFFFF, 0, 16'hFFFF, 1, 0);
      snd_idle_pct = 9; rcv_idle_pct = 83;
      random_items(620);

      // low extremes; the other way round
      quiesce();
      load_regs(0, 0, 16'hFFFF, 0, 16'hFFFF, 10'h3FF);
      snd_idle_pct = 83; rcv_idle_pct = 9;
      random_items(620);

      // mid-range values with a short timeout; no idling, long receiver hold-off
      quiesce();
      begin
         int tc;
         tc = $urandom_range(2000, 300);
         load_regs($urandom_range(22'h3FFFFF), $urandom_range(2000, 200), tc,
                   tc + $urandom_range(800), $urandom_range(30, 3), $urandom_range(1023));
      end
      snd_idle_pct = 0; rcv_idle_pct = 0;
      hold_off = 1'b1;
      random_items(620);

      @(negedge clock);
      req_valid <= 1'b0;
      wait (speed_q.size() == 0);
      repeat (500) @(posedge clock);

      $display("Covered %0d refresh results: coarse %0d, precise %0d, zero %0d;",
               n_refresh, mode_hits[MODE_COARSE], mode_hits[MODE_PRECISE],
               mode_hits[MODE_ZERO]);
      $display("  %0d at the speed cap, %0d record flags, four register settings.",
               n_sat, n_flag);
      if (n_fail == 0) begin
         $display("[pulse_speed_meter] OK");
      end else begin
         $display("[pulse_speed_meter] ERROR");
      end
      $finish;
   end

endmodule
